// ----- hw/rtl/bspmc_pkg.sv -----
// ----------------------------------------------------------------------------
// bspmc_pkg
// Shared types, codes and constants of the battery SOC and power mode
// controller: opcodes, mode codes, register indexes and load patterns.
// ----------------------------------------------------------------------------
package bspmc_pkg;

  localparam int SocW    = 24;
  localparam int CountW  = 18;
  localparam int VoltW   = 13;
  localparam int SStepW  = 16;
  localparam int CStepW  = 10;
  localparam int ModeW   = 8;
  localparam int SwW     = 7;
  localparam int OpW     = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 24;
  localparam int InDatW  = 80;
  localparam int OutDatW = 64;

  localparam logic [SocW-1:0] SOC_ONE = 24'd8388608;

  // opcodes
  localparam logic [OpW-1:0] OP_PULSE    = 3'd0;
  localparam logic [OpW-1:0] OP_TICK     = 3'd1;
  localparam logic [OpW-1:0] OP_SET_MODE = 3'd2;
  localparam logic [OpW-1:0] OP_RESTORE  = 3'd3;
  localparam logic [OpW-1:0] OP_INIT_SOC = 3'd4;
  localparam logic [OpW-1:0] OP_ACK      = 3'd5;

  // modes
  localparam logic [ModeW-1:0] MODE_DETUMBLE  = 8'd0;
  localparam logic [ModeW-1:0] MODE_CRITICAL  = 8'd1;
  localparam logic [ModeW-1:0] MODE_SURVIVAL  = 8'd2;
  localparam logic [ModeW-1:0] MODE_LOW_POWER = 8'd3;
  localparam logic [ModeW-1:0] MODE_IDLE      = 8'd4;
  localparam logic [ModeW-1:0] MODE_NORMAL    = 8'd5;
  localparam logic [ModeW-1:0] MODE_NONE      = 8'd255;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_CRIT_TH     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SURV_TH     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LOWPWR_TH   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CHARGED_MV  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SOC_STEP    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CHARGE_STEP = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CAPACITY    = 3'd6;

  // register reset values
  localparam logic [SocW-1:0]   RST_CRIT_TH     = 24'd2097152;
  localparam logic [SocW-1:0]   RST_SURV_TH     = 24'd2516582;
  localparam logic [SocW-1:0]   RST_LOWPWR_TH   = 24'd3355443;
  localparam logic [VoltW-1:0]  RST_CHARGED_MV  = 13'd7100;
  localparam logic [SStepW-1:0] RST_SOC_STEP    = 16'd1526;
  localparam logic [CStepW-1:0] RST_CHARGE_STEP = 10'd25;
  localparam logic [CountW-1:0] RST_CAPACITY    = 18'd129600;

  typedef struct packed {
    logic [VoltW-1:0]  voltage_mv;
    logic              charge_dir;
    logic [ModeW-1:0]  mode_value;
    logic [15:0]       mode_primary;
    logic [15:0]       mode_redundant;
    logic [SocW-1:0]   soc_init;
    logic [OpW-1:0]    opcode;
  } in_item_t;

  // Load pattern of a mode; valid only for modes below MODE_NORMAL + 1.
  function automatic logic [SwW-1:0] load_pattern(input logic [ModeW-1:0] m);
    logic [SwW-1:0] p;
    unique case (m)
      MODE_DETUMBLE:  p = 7'h03;
      MODE_CRITICAL:  p = 7'h00;
      MODE_SURVIVAL:  p = 7'h05;
      MODE_LOW_POWER: p = 7'h0F;
      MODE_IDLE:      p = 7'h0D;
      MODE_NORMAL:    p = 7'h1F;
      default:        p = 7'h00;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/battery_soc_power_mode_controller.sv -----
// ----------------------------------------------------------------------------
// battery_soc_power_mode_controller
// Coulomb count, state-of-charge estimate, power mode selection and load
// switch control, one result word per input word.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tuser opcode, s_tdata item fields
//  m_*      out  m_tvalid/m_tready   m_tdata result fields
//  cfg_*    in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// Each word passes the input register, then the update logic into the result
// register; a new word can enter every cycle unless m_tready stalls. State
// updates at the edge that loads the result, so back-to-back words see each
// other's effects. A stall on m_tready holds the result and backs up into the
// input register; s_tready drops only when both are full. rst clears the
// flags and loads registers and state with reset values; cfg writes never wait.
// ----------------------------------------------------------------------------
module battery_soc_power_mode_controller
  import bspmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // stream in
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [OpW-1:0]      s_tuser,   // opcode
  // [0] charge_dir, [13:1] voltage_mv, [21:14] mode_value,
  // [37:22] mode_primary, [53:38] mode_redundant, [77:54] soc_init, rest 0
  input  logic [InDatW-1:0]   s_tdata,
  // stream out
  output logic                m_tvalid,
  input  logic                m_tready,
  // [7:0] mode, [8] mode_changed, [15:9] load_switches,
  // [16] switches_updated, [40:17] soc, [58:41] charge_count, rest 0
  output logic [OutDatW-1:0]  m_tdata,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDatW-1:0]  cfg_data
);

  // configuration registers
  logic [SocW-1:0]   crit_th;
  logic [SocW-1:0]   surv_th;
  logic [SocW-1:0]   lowpwr_th;
  logic [VoltW-1:0]  charged_mv;
  logic [SStepW-1:0] soc_step;
  logic [CStepW-1:0] charge_step;
  logic [CountW-1:0] capacity;

  // controller state
  logic [ModeW-1:0]  current_mode, current_mode_next;
  logic [ModeW-1:0]  applied_mode, applied_mode_next;
  logic [SwW-1:0]    switch_pattern, switch_pattern_next;
  logic [SocW-1:0]   soc_est, soc_est_next;
  logic [CountW-1:0] charge_total, charge_total_next;
  logic              updated;

  // pipeline
  logic              in_valid;
  in_item_t          in_item;
  logic              advance;

  logic [CountW:0]   count_sum;
  logic [SocW:0]     soc_sum;
  logic [ModeW-1:0]  tick_mode;

  assign cfg_ready = 1'b1;

  // Move the held word into the result register when that slot frees up.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      crit_th     <= RST_CRIT_TH;
      surv_th     <= RST_SURV_TH;
      lowpwr_th   <= RST_LOWPWR_TH;
      charged_mv  <= RST_CHARGED_MV;
      soc_step    <= RST_SOC_STEP;
      charge_step <= RST_CHARGE_STEP;
      capacity    <= RST_CAPACITY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CRIT_TH:     crit_th     <= cfg_data;
        REG_SURV_TH:     surv_th     <= cfg_data;
        REG_LOWPWR_TH:   lowpwr_th   <= cfg_data;
        REG_CHARGED_MV:  charged_mv  <= cfg_data[VoltW-1:0];
        REG_SOC_STEP:    soc_step    <= cfg_data[SStepW-1:0];
        REG_CHARGE_STEP: charge_step <= cfg_data[CStepW-1:0];
        REG_CAPACITY:    capacity    <= cfg_data[CountW-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.opcode         <= s_tuser;
      in_item.charge_dir     <= s_tdata[0];
      in_item.voltage_mv     <= s_tdata[13:1];
      in_item.mode_value     <= s_tdata[21:14];
      in_item.mode_primary   <= s_tdata[37:22];
      in_item.mode_redundant <= s_tdata[53:38];
      in_item.soc_init       <= s_tdata[77:54];
    end
  end

  assign count_sum = {1'b0, charge_total} + {{(CountW+1-CStepW){1'b0}}, charge_step};
  assign soc_sum   = {1'b0, soc_est} + {{(SocW+1-SStepW){1'b0}}, soc_step};

  // Threshold ladder of the monitor tick: critical is checked first, then survival, then low power.
  always_comb begin
    priority if (soc_est < crit_th) begin
      tick_mode = MODE_CRITICAL;
    end else if (soc_est < surv_th) begin
      tick_mode = MODE_SURVIVAL;
    end else if (soc_est < lowpwr_th) begin
      tick_mode = MODE_LOW_POWER;
    end else begin
      tick_mode = current_mode;
    end
  end

  always_comb begin
    current_mode_next   = current_mode;
    applied_mode_next   = applied_mode;
    switch_pattern_next = switch_pattern;
    soc_est_next        = soc_est;
    charge_total_next   = charge_total;
    updated             = 1'b0;
    unique case (in_item.opcode)
      OP_PULSE: begin
        if (in_item.charge_dir) begin
          charge_total_next = (count_sum > {1'b0, capacity}) ? capacity
                                                             : count_sum[CountW-1:0];
          soc_est_next = (soc_sum > {1'b0, SOC_ONE}) ? SOC_ONE : soc_sum[SocW-1:0];
        end else begin
          charge_total_next = (charge_total > {{(CountW-CStepW){1'b0}}, charge_step})
                            ? charge_total - {{(CountW-CStepW){1'b0}}, charge_step}
                            : '0;
          if (in_item.voltage_mv > charged_mv) begin
            soc_est_next = SOC_ONE;
          end else begin
            soc_est_next = (soc_est > {{(SocW-SStepW){1'b0}}, soc_step})
                         ? soc_est - {{(SocW-SStepW){1'b0}}, soc_step}
                         : '0;
          end
        end
      end
      OP_TICK: begin
        current_mode_next = tick_mode;
        if (tick_mode != applied_mode) begin
          // modes above normal have no pattern: keep the switches
          if (tick_mode <= MODE_NORMAL) begin
            switch_pattern_next = load_pattern(tick_mode);
            updated             = 1'b1;
          end
          applied_mode_next = tick_mode;
        end
      end
      OP_SET_MODE: current_mode_next = in_item.mode_value;
      OP_RESTORE: begin
        current_mode_next = (in_item.mode_primary == in_item.mode_redundant)
                          ? in_item.mode_primary[ModeW-1:0] : MODE_IDLE;
      end
      OP_INIT_SOC: soc_est_next = (in_item.soc_init > SOC_ONE) ? SOC_ONE : in_item.soc_init;
      OP_ACK:      applied_mode_next = current_mode;
      default: ;  // unused opcodes: report state only
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode   <= MODE_LOW_POWER;
      applied_mode   <= MODE_NONE;
      switch_pattern <= '0;
      soc_est        <= '0;
      charge_total   <= RST_CAPACITY;
      m_tvalid       <= 1'b0;
    end else begin
      if (advance) begin
        current_mode   <= current_mode_next;
        applied_mode   <= applied_mode_next;
        switch_pattern <= switch_pattern_next;
        soc_est        <= soc_est_next;
        charge_total   <= charge_total_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(OutDatW-59){1'b0}},
                  charge_total_next,
                  soc_est_next,
                  updated,
                  switch_pattern_next,
                  (current_mode_next != applied_mode_next),
                  current_mode_next};
    end
  end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the battery SOC and power mode controller. A short
// table of directed command words runs first, then random command words
// under several register settings. Every result word is compared field by
// field with its expected word, typed in the table or from a bit-exact model.
// ----------------------------------------------------------------------------
module tb
  import bspmc_pkg::*;
();

  // codes the package leaves unnamed
  localparam logic [OpW-1:0]     OP_SPARE_LO  = 3'd6;
  localparam logic [OpW-1:0]     OP_SPARE_HI  = 3'd7;
  localparam logic [ModeW-1:0]   MODE_SUN     = 8'd6;
  localparam logic [ModeW-1:0]   MODE_SCIENCE = 8'd7;
  localparam logic [CfgIdxW-1:0] REG_UNUSED   = 3'd7;

  localparam int NUM_WRITES      = 8;    // seven registers plus the unused index
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 225;
  localparam int DRAIN_CYCLES    = 8;    // input and result registers, with margin
  localparam int HOLD_AT         = 500;  // result words before the long back-pressure
  localparam int HOLD_CYCLES     = 60;
  // The longest quiet spell of a correct run is the long hold plus a drain;
  // random gaps are short geometric runs. Allow far more.
  localparam int STALL_LIMIT     = 1000;

  // load pattern per mode, detumble at index 0
  localparam logic [5:0][SwW-1:0] SWITCH_SET =
    {7'h1F, 7'h0D, 7'h0F, 7'h05, 7'h00, 7'h03};

  typedef struct {
    logic [OpW-1:0]   opcode;
    logic             charge_dir;
    logic [VoltW-1:0] voltage_mv;
    logic [ModeW-1:0] mode_value;
    logic [15:0]      mode_primary;
    logic [15:0]      mode_redundant;
    logic [SocW-1:0]  soc_init;
  } cmd_t;

  typedef struct {
    logic [ModeW-1:0]  mode;
    logic              mode_changed;
    logic [SwW-1:0]    load_switches;
    logic              switches_updated;
    logic [SocW-1:0]   soc;
    logic [CountW-1:0] charge_count;
  } status_t;

  typedef struct {
    cmd_t    cmd;
    bit      known;   // expected word typed in the table
    status_t want;
  } row_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [OpW-1:0]     s_tuser;   // opcode
  // [0] charge_dir, [13:1] voltage_mv, [21:14] mode_value,
  // [37:22] mode_primary, [53:38] mode_redundant, [77:54] soc_init, rest 0
  logic [InDatW-1:0]  s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  // [7:0] mode, [8] mode_changed, [15:9] load_switches,
  // [16] switches_updated, [40:17] soc, [58:41] charge_count, rest 0
  logic [OutDatW-1:0] m_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDatW-1:0] cfg_data;

  // model registers
  logic [SocW-1:0]    th_crit, th_surv, th_low;
  logic [VoltW-1:0]   full_mv;
  logic [SStepW-1:0]  soc_inc;
  logic [CStepW-1:0]  count_inc;
  logic [CountW-1:0]  count_cap;
  // model state
  logic [ModeW-1:0]   mode_now, mode_applied;
  logic [SwW-1:0]     switches_now;
  logic [SocW-1:0]    soc_now;
  logic [CountW-1:0]  count_now;

  status_t status_due[$];   // expected result words, oldest first
  row_t    plan[$];         // directed table
  int      faults;
  bit      steady;          // no idling on either side while set

  battery_soc_power_mode_controller i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the model by one command word and return the result word it
  // produces.
  function automatic status_t advance_controller(input cmd_t c);
    status_t           s;
    logic [CountW:0]   cnt_sum;
    logic [SocW:0]     soc_sum;
    logic              hit;
    hit = 1'b0;
    case (c.opcode)
      OP_PULSE: begin
        if (c.charge_dir) begin
          cnt_sum   = count_now + count_inc;
          soc_sum   = soc_now + soc_inc;
          count_now = (cnt_sum > count_cap) ? count_cap : cnt_sum[CountW-1:0];
          soc_now   = (soc_sum > SOC_ONE) ? SOC_ONE : soc_sum[SocW-1:0];
        end else begin
          // discharge floors at zero only, even above a lowered capacity
          count_now = (count_now > count_inc) ? count_now - count_inc : '0;
          if (c.voltage_mv > full_mv) begin
            soc_now = SOC_ONE;
          end else begin
            soc_now = (soc_now > soc_inc) ? soc_now - soc_inc : '0;
          end
        end
      end
      OP_TICK: begin
        if (soc_now < th_crit) begin
          mode_now = MODE_CRITICAL;
        end else if (soc_now < th_surv) begin
          mode_now = MODE_SURVIVAL;
        end else if (soc_now < th_low) begin
          mode_now = MODE_LOW_POWER;
        end
        if (mode_now != mode_applied) begin
          // modes past normal carry no pattern but still count as applied
          if (mode_now <= MODE_NORMAL) begin
            switches_now = SWITCH_SET[mode_now[2:0]];
            hit          = 1'b1;
          end
          mode_applied = mode_now;
        end
      end
      OP_SET_MODE: mode_now = c.mode_value;
      OP_RESTORE: begin
        mode_now = (c.mode_primary == c.mode_redundant) ? c.mode_primary[7:0] : MODE_IDLE;
      end
      OP_INIT_SOC: soc_now = (c.soc_init > SOC_ONE) ? SOC_ONE : c.soc_init;
      OP_ACK:      mode_applied = mode_now;
      default: ;
    endcase
    s.mode             = mode_now;
    s.mode_changed     = (mode_now != mode_applied);
    s.load_switches    = switches_now;
    s.switches_updated = hit;
    s.soc              = soc_now;
    s.charge_count     = count_now;
    return s;
  endfunction

  function automatic cmd_t mk(input logic [OpW-1:0] op, input logic dir,
                              input logic [VoltW-1:0] volt, input logic [ModeW-1:0] mval,
                              input logic [15:0] prim, input logic [15:0] redu,
                              input logic [SocW-1:0] sinit);
    cmd_t c;
    c.opcode         = op;
    c.charge_dir     = dir;
    c.voltage_mv     = volt;
    c.mode_value     = mval;
    c.mode_primary   = prim;
    c.mode_redundant = redu;
    c.soc_init       = sinit;
    return c;
  endfunction

  function automatic status_t st(input logic [ModeW-1:0] mode, input logic chg,
                                 input logic [SwW-1:0] sw, input logic upd,
                                 input logic [SocW-1:0] soc, input logic [CountW-1:0] cnt);
    status_t s;
    s.mode             = mode;
    s.mode_changed     = chg;
    s.load_switches    = sw;
    s.switches_updated = upd;
    s.soc              = soc;
    s.charge_count     = cnt;
    return s;
  endfunction

  function automatic row_t pin(input cmd_t c, input status_t s);
    row_t r;
    r.cmd   = c;
    r.known = 1'b1;
    r.want  = s;
    return r;
  endfunction

  function automatic row_t open_row(input cmd_t c);
    row_t r;
    r.cmd   = c;
    r.known = 1'b0;
    r.want  = st('0, 1'b0, '0, 1'b0, '0, '0);
    return r;
  endfunction

  // Random command word: mostly pulses and ticks so the estimate crosses the
  // thresholds; voltages cluster around the charged threshold half the time
  // and copies for restore agree most of the time.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   k;
    int   v;
    k = $urandom_range(99);
    if (k < 40)      c.opcode = OP_PULSE;
    else if (k < 62) c.opcode = OP_TICK;
    else if (k < 72) c.opcode = OP_SET_MODE;
    else if (k < 82) c.opcode = OP_RESTORE;
    else if (k < 90) c.opcode = OP_INIT_SOC;
    else if (k < 97) c.opcode = OP_ACK;
    else             c.opcode = k[0] ? OP_SPARE_LO : OP_SPARE_HI;
    c.charge_dir = 1'($urandom_range(1));
    if ($urandom_range(1) == 1) begin
      c.voltage_mv = VoltW'($urandom());
    end else begin
      k = $urandom_range(8);
      v = int'(full_mv) + k - 4;
      c.voltage_mv = (v < 0) ? '0 : (v > 8191) ? '1 : VoltW'(v);
    end
    c.mode_value = ($urandom_range(3) == 0) ? ModeW'($urandom()) : ModeW'($urandom_range(MODE_SCIENCE));
    c.mode_primary[15:8] = 8'($urandom());
    c.mode_primary[7:0]  = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(MODE_SCIENCE));
    if ($urandom_range(9) < 6) begin
      c.mode_redundant = c.mode_primary;
    end else if ($urandom_range(1) == 1) begin
      c.mode_redundant = 16'($urandom());
    end else begin
      c.mode_redundant = c.mode_primary ^ (16'h1 << $urandom_range(15));
    end
    c.soc_init = ($urandom_range(9) == 0) ? SocW'($urandom()) : SocW'($urandom_range(SOC_ONE));
    return c;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      faults++;
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Offer one command word, holding it until accepted, then log its result.
  task automatic send_cmd(input row_t r);
    status_t model;
    while (!steady && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.cmd.opcode;
    s_tdata  <= {2'b00, r.cmd.soc_init, r.cmd.mode_redundant, r.cmd.mode_primary,
                 r.cmd.mode_value, r.cmd.voltage_mv, r.cmd.charge_dir};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model = advance_controller(r.cmd);
    status_due.push_back(r.known ? r.want : model);
  endtask

  // Drop valid, let every result word come back, then let the pipe settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all registers back to back, then the unused index.
  task automatic load_settings(input logic [CfgDatW-1:0] vals [NUM_WRITES]);
    logic [CfgIdxW-1:0] idx;
    for (int i = 0; i < NUM_WRITES; i++) begin
      idx = i[CfgIdxW-1:0];
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        REG_CRIT_TH:     th_crit   = vals[i][SocW-1:0];
        REG_SURV_TH:     th_surv   = vals[i][SocW-1:0];
        REG_LOWPWR_TH:   th_low    = vals[i][SocW-1:0];
        REG_CHARGED_MV:  full_mv   = vals[i][VoltW-1:0];
        REG_SOC_STEP:    soc_inc   = vals[i][SStepW-1:0];
        REG_CHARGE_STEP: count_inc = vals[i][CStepW-1:0];
        REG_CAPACITY:    count_cap = vals[i][CountW-1:0];
        REG_UNUSED:      ;   // ignored by the block
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: check every accepted word, idle at random, and hold off
  // once for a long stretch so the block fills and stalls its input.
  initial begin
    status_t got;
    status_t want;
    int      words_out;
    int      hold_left;
    bit      held;
    words_out = 0;
    hold_left = 0;
    held      = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got.mode             = m_tdata[7:0];
        got.mode_changed     = m_tdata[8];
        got.load_switches    = m_tdata[15:9];
        got.switches_updated = m_tdata[16];
        got.soc              = m_tdata[40:17];
        got.charge_count     = m_tdata[58:41];
        words_out++;
        if (status_due.size() == 0) begin
          faults++;
          $display("%0t result word: expected none, got 0x%h", $time, m_tdata);
        end else begin
          want = status_due.pop_front();
          check_field("mode", 32'(want.mode), 32'(got.mode));
          check_field("mode_changed", 32'(want.mode_changed), 32'(got.mode_changed));
          check_field("load_switches", 32'(want.load_switches), 32'(got.load_switches));
          check_field("switches_updated", 32'(want.switches_updated),
                      32'(got.switches_updated));
          check_field("soc", 32'(want.soc), 32'(got.soc));
          check_field("charge_count", 32'(want.charge_count), 32'(got.charge_count));
        end
      end
      if (!held && words_out >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 33);
      end
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [CfgDatW-1:0] vals [NUM_WRITES];
    logic [CfgDatW-1:0] lo;
    faults    = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= '0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    steady    <= 1'b0;

    th_crit      = RST_CRIT_TH;
    th_surv      = RST_SURV_TH;
    th_low       = RST_LOWPWR_TH;
    full_mv      = RST_CHARGED_MV;
    soc_inc      = RST_SOC_STEP;
    count_inc    = RST_CHARGE_STEP;
    count_cap    = RST_CAPACITY;
    mode_now     = MODE_LOW_POWER;
    mode_applied = MODE_NONE;
    switches_now = '0;
    soc_now      = '0;
    count_now    = RST_CAPACITY;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table, under the reset register values.
    // spare opcode with every field at its top: nothing moves
    plan.push_back(pin(mk(OP_SPARE_HI, 1'b1, '1, '1, '1, '1, '1),
                       st(MODE_LOW_POWER, 1'b1, 7'h00, 1'b0, '0, RST_CAPACITY)));
    // first tick on an empty estimate: critical hold, its pattern applied
    plan.push_back(pin(mk(OP_TICK, 1'b0, '0, '0, '0, '0, '0),
                       st(MODE_CRITICAL, 1'b0, 7'h00, 1'b1, '0, RST_CAPACITY)));
    // oversized init saturates to full
    plan.push_back(pin(mk(OP_INIT_SOC, 1'b0, '0, '0, '0, '0, '1),
                       st(MODE_CRITICAL, 1'b0, 7'h00, 1'b0, SOC_ONE, RST_CAPACITY)));
    // charge at full count and full estimate: both saturate
    plan.push_back(pin(mk(OP_PULSE, 1'b1, '0, '0, '0, '0, '0),
                       st(MODE_CRITICAL, 1'b0, 7'h00, 1'b0, SOC_ONE, RST_CAPACITY)));
    // discharge above the charged voltage: estimate forced full, count drops
    plan.push_back(pin(mk(OP_PULSE, 1'b0, '1, '0, '0, '0, '0),
                       st(MODE_CRITICAL, 1'b0, 7'h00, 1'b0, SOC_ONE,
                          RST_CAPACITY - CountW'(RST_CHARGE_STEP))));
    // discharge exactly at the charged voltage steps the estimate down
    plan.push_back(open_row(mk(OP_PULSE, 1'b0, RST_CHARGED_MV, '0, '0, '0, '0)));
    // mode with no pattern: applied, switches kept
    plan.push_back(open_row(mk(OP_SET_MODE, 1'b0, '0, MODE_NONE, '0, '0, '0)));
    plan.push_back(open_row(mk(OP_TICK, 1'b0, '0, '0, '0, '0, '0)));
    plan.push_back(open_row(mk(OP_SET_MODE, 1'b0, '0, MODE_DETUMBLE, '0, '0, '0)));
    plan.push_back(open_row(mk(OP_TICK, 1'b0, '0, '0, '0, '0, '0)));
    plan.push_back(open_row(mk(OP_SET_MODE, 1'b0, '0, MODE_NORMAL, '0, '0, '0)));
    plan.push_back(open_row(mk(OP_TICK, 1'b0, '0, '0, '0, '0, '0)));
    plan.push_back(open_row(mk(OP_SET_MODE, 1'b0, '0, MODE_SUN, '0, '0, '0)));
    plan.push_back(open_row(mk(OP_TICK, 1'b0, '0, '0, '0, '0, '0)));
    // matching copies restore the low byte; differing copies fall back to idle
    plan.push_back(open_row(mk(OP_RESTORE, 1'b0, '0, '0, 16'hFF04, 16'hFF04, '0)));
    plan.push_back(open_row(mk(OP_TICK, 1'b0, '0, '0, '0, '0, '0)));
    plan.push_back(open_row(mk(OP_RESTORE, 1'b0, '0, '0, 16'h0002, 16'h8002, '0)));
    plan.push_back(open_row(mk(OP_SET_MODE, 1'b0, '0, MODE_SCIENCE, '0, '0, '0)));
    plan.push_back(open_row(mk(OP_ACK, 1'b0, '0, '0, '0, '0, '0)));
    // estimate between survival and low power, then between critical and survival
    plan.push_back(open_row(mk(OP_INIT_SOC, 1'b0, '0, '0, '0, '0, 24'd3000000)));
    plan.push_back(open_row(mk(OP_TICK, 1'b0, '0, '0, '0, '0, '0)));
    plan.push_back(open_row(mk(OP_INIT_SOC, 1'b0, '0, '0, '0, '0, 24'd2300000)));
    plan.push_back(open_row(mk(OP_TICK, 1'b0, '0, '0, '0, '0, '0)));
    // discharge below one step floors the estimate at zero
    plan.push_back(open_row(mk(OP_INIT_SOC, 1'b0, '0, '0, '0, '0, 24'd1000)));
    plan.push_back(open_row(mk(OP_PULSE, 1'b0, '0, '0, '0, '0, '0)));
    plan.push_back(open_row(mk(OP_SPARE_LO, 1'b0, '0, '0, '0, '0, '0)));

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        foreach (plan[i]) send_cmd(plan[i]);
      end else begin
        wait_idle();
        case (p)
          // thresholds off, huge steps, top capacity
          1: vals = '{24'd0, 24'd0, 24'd0, 24'd8191, 24'd65535, 24'd1023, 24'd262143, 24'd0};
          // always below every threshold, no steps, zero capacity
          2: vals = '{'1, '1, '1, 24'd0, 24'd0, 24'd0, 24'd0, '1};
          // no idling anywhere; fast steps around the default thresholds
          3: vals = '{RST_CRIT_TH, RST_SURV_TH, RST_LOWPWR_TH, 24'(RST_CHARGED_MV),
                      24'd40000, 24'd1000, 24'd200000, 24'd5};
          // random ordered thresholds and random steps
          4: begin
            lo      = 24'($urandom_range(3000000));
            vals[0] = lo;
            vals[1] = lo + 24'($urandom_range(2000000));
            vals[2] = vals[1] + 24'($urandom_range(3000000));
            vals[3] = 24'($urandom_range(8191));
            vals[4] = 24'($urandom_range(65535));
            vals[5] = 24'($urandom_range(1023));
            vals[6] = 24'($urandom_range(262143));
            vals[7] = 24'($urandom());
          end
          // raw random words, bits above each register width included
          5: foreach (vals[i]) vals[i] = 24'($urandom());
          // thresholds inverted, capacity below the current count
          6: vals = '{24'd6000000, 24'd4000000, 24'd2000000, 24'd4096,
                      24'd40000, 24'd512, 24'd1000, 24'd0};
          default: vals = '{RST_CRIT_TH, RST_SURV_TH, RST_LOWPWR_TH, 24'(RST_CHARGED_MV),
                            24'(RST_SOC_STEP), 24'(RST_CHARGE_STEP), 24'(RST_CAPACITY), 24'd0};
        endcase
        load_settings(vals);
      end
      steady <= (p == 3);
      repeat (WORDS_PER_PHASE) send_cmd(open_row(random_cmd()));
    end

    wait_idle();
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/bspmc_pkg.sv
hw/rtl/battery_soc_power_mode_controller.sv
test/tb.sv
